// File: design/mpds_pkg.sv
// Shared types, command codes and defaults for the multi-pattern DFA scanner.
package mpds_pkg;

    localparam int STATE_COUNT_DEF  = 256;
    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MAX_CHAIN_DEF    = 16;
    localparam int TABLE_LIMIT      = 256;

    typedef enum logic [2:0] {
        CMD_SCAN       = 3'd0,
        CMD_WRITE_EDGE = 3'd1,
        CMD_WRITE_TERM = 3'd2,
        CMD_WRITE_LINK = 3'd3,
        CMD_RESTART    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRANS,
        ST_WALK,
        ST_DONE
    } fsm_t;

    typedef struct packed {
        logic       we;
        logic [7:0] sym;
        logic [7:0] st;
        logic [7:0] wdata;
    } tmem_req_t;

    typedef struct packed {
        logic       we_term;
        logic       we_link;
        logic [7:0] addr;
        logic       term_wdata;
        logic [7:0] link_wdata;
    } nmem_req_t;

    typedef struct packed {
        logic       term;
        logic [7:0] link;
    } nmem_rsp_t;

    function automatic int clip_count(input int n);
        return (n < TABLE_LIMIT) ? n : TABLE_LIMIT;
    endfunction

endpackage

// File: design/multi_pattern_dfa_scanner_unit.sv
// Multi-pattern DFA scanner top level: automaton memories and walk sequencer.
// A table write, restart or unknown command completes on its transfer; busy stays low after it.
// A scan byte holds busy while k states on the suffix-link chain are examined, k being
// 1 to MAX_CHAIN, or 0 when the byte leads to the root: one transition memory read in ST_TRANS,
// then one node memory read per chain state in ST_WALK, then ST_DONE flushes the last result.
// Results come at most one per cycle on match_valid, the last one in the same cycle that busy falls.
// Reset clears the current state and byte position to zero; the tables hold no reset value.
module multi_pattern_dfa_scanner_unit #(
    parameter int STATE_COUNT  = mpds_pkg::STATE_COUNT_DEF,
    parameter int SYMBOL_COUNT = mpds_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CHAIN    = mpds_pkg::MAX_CHAIN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [7:0]  symbol,
    input  logic [7:0]  state_index,
    input  logic [7:0]  table_value,
    output logic        match_valid,
    output logic [31:0] position,
    output logic [7:0]  match_state,
    output logic        last_match
);
    import mpds_pkg::*;

    tmem_req_t  tmem_req;
    logic [7:0] tmem_rdata;
    nmem_req_t  nmem_req;
    nmem_rsp_t  nmem_rsp;

    mpds_tmem #(
        .STATE_COUNT  (STATE_COUNT),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_tmem (
        .clk   (clk),
        .req   (tmem_req),
        .rdata (tmem_rdata)
    );

    mpds_nmem #(
        .STATE_COUNT (STATE_COUNT)
    ) u_nmem (
        .clk (clk),
        .req (nmem_req),
        .rsp (nmem_rsp)
    );

    mpds_ctrl #(
        .STATE_COUNT  (STATE_COUNT),
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CHAIN    (MAX_CHAIN)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .symbol      (symbol),
        .state_index (state_index),
        .table_value (table_value),
        .tmem_req    (tmem_req),
        .tmem_rdata  (tmem_rdata),
        .nmem_req    (nmem_req),
        .nmem_rsp    (nmem_rsp),
        .match_valid (match_valid),
        .position    (position),
        .match_state (match_state),
        .last_match  (last_match)
    );

endmodule

// File: design/mpds_tmem.sv
// Transition memory: next state indexed by symbol and current state.
module mpds_tmem #(
    parameter int STATE_COUNT  = mpds_pkg::STATE_COUNT_DEF,
    parameter int SYMBOL_COUNT = mpds_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                 clk,
    input  mpds_pkg::tmem_req_t  req,
    output logic [7:0]           rdata
);
    import mpds_pkg::*;

    localparam int STATES = clip_count(STATE_COUNT);
    localparam int SYMS   = clip_count(SYMBOL_COUNT);
    localparam int NAW    = $clog2(STATES);
    localparam int SAW    = $clog2(SYMS);
    localparam int DEPTH  = 1 << (NAW + SAW);

    logic [7:0]           mem [DEPTH];
    logic [NAW+SAW-1:0]   addr;

    assign addr = {req.sym[SAW-1:0], req.st[NAW-1:0]};

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[addr] <= req.wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: design/mpds_nmem.sv
// Node memory: terminal mark and suffix link of every state.
module mpds_nmem #(
    parameter int STATE_COUNT = mpds_pkg::STATE_COUNT_DEF
) (
    input  logic                 clk,
    input  mpds_pkg::nmem_req_t  req,
    output mpds_pkg::nmem_rsp_t  rsp
);
    import mpds_pkg::*;

    localparam int STATES = clip_count(STATE_COUNT);
    localparam int NAW    = $clog2(STATES);

    logic [8:0]     mem [STATES];
    logic [NAW-1:0] addr;

    assign addr = req.addr[NAW-1:0];

    always_ff @(posedge clk)
    begin
        if (req.we_term)
        begin
            mem[addr][8] <= req.term_wdata;
        end
        if (req.we_link)
        begin
            mem[addr][7:0] <= req.link_wdata;
        end
        rsp <= nmem_rsp_t'(mem[addr]);
    end

endmodule

// File: design/mpds_ctrl.sv
// Command decoder and suffix-link walk sequencer with the result register.
module mpds_ctrl #(
    parameter int STATE_COUNT  = mpds_pkg::STATE_COUNT_DEF,
    parameter int SYMBOL_COUNT = mpds_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CHAIN    = mpds_pkg::MAX_CHAIN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           command,
    input  logic [7:0]           symbol,
    input  logic [7:0]           state_index,
    input  logic [7:0]           table_value,
    output mpds_pkg::tmem_req_t  tmem_req,
    input  logic [7:0]           tmem_rdata,
    output mpds_pkg::nmem_req_t  nmem_req,
    input  mpds_pkg::nmem_rsp_t  nmem_rsp,
    output logic                 match_valid,
    output logic [31:0]          position,
    output logic [7:0]           match_state,
    output logic                 last_match
);
    import mpds_pkg::*;

    localparam int         STATES    = clip_count(STATE_COUNT);
    localparam int         SYMS      = clip_count(SYMBOL_COUNT);
    localparam logic [8:0] STATE_LIM = 9'(STATES);
    localparam logic [8:0] SYM_LIM   = 9'(SYMS);
    localparam int         SW        = $clog2(MAX_CHAIN + 1);
    localparam logic [SW-1:0] CHAIN_LIM = SW'(MAX_CHAIN);

    fsm_t          fsm_reg, fsm_next;
    logic [7:0]    cur_state_reg, cur_state_next;
    logic [31:0]   pos_reg, pos_next;
    logic [7:0]    node_reg, node_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic          sym_ok_reg, sym_ok_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_state_reg, pend_state_next;
    logic          out_valid_reg;
    logic [31:0]   out_pos_reg;
    logic [7:0]    out_state_reg;
    logic          out_last_reg;

    cmd_t          cmd;
    logic          accept;
    logic          sym_ok;
    logic          st_ok;
    logic [7:0]    trans_node;
    logic          walk_end;
    logic          emit_valid;
    logic [7:0]    emit_state;
    logic          emit_last;

    assign cmd        = cmd_t'(command);
    assign busy       = (fsm_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign sym_ok     = ({1'b0, symbol} < SYM_LIM);
    assign st_ok      = ({1'b0, state_index} < STATE_LIM);
    assign trans_node = sym_ok_reg ? tmem_rdata : 8'd0;
    assign walk_end   = (steps_reg == CHAIN_LIM) || (nmem_rsp.link == 8'd0);

    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_SCAN))
                begin
                    fsm_next = ST_TRANS;
                end
            end
            ST_TRANS:
            begin
                fsm_next = (trans_node == 8'd0) ? ST_DONE : ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    fsm_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                fsm_next = ST_IDLE;
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_state_next  = cur_state_reg;
        pos_next        = pos_reg;
        node_next       = node_reg;
        steps_next      = steps_reg;
        sym_ok_next     = sym_ok_reg;
        pend_valid_next = pend_valid_reg;
        pend_state_next = pend_state_reg;
        emit_valid      = 1'b0;
        emit_state      = pend_state_reg;
        emit_last       = 1'b0;

        tmem_req.we    = 1'b0;
        tmem_req.sym   = symbol;
        tmem_req.st    = cur_state_reg;
        tmem_req.wdata = table_value;

        nmem_req.we_term    = 1'b0;
        nmem_req.we_link    = 1'b0;
        nmem_req.addr       = state_index;
        nmem_req.term_wdata = (table_value != 8'd0);
        nmem_req.link_wdata = table_value;

        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_SCAN:
                        begin
                            sym_ok_next     = sym_ok;
                            pend_valid_next = 1'b0;
                        end
                        CMD_WRITE_EDGE:
                        begin
                            tmem_req.we = sym_ok && st_ok;
                            tmem_req.st = state_index;
                        end
                        CMD_WRITE_TERM:
                        begin
                            nmem_req.we_term = st_ok;
                        end
                        CMD_WRITE_LINK:
                        begin
                            nmem_req.we_link = st_ok;
                        end
                        CMD_RESTART:
                        begin
                            cur_state_next = 8'd0;
                            pos_next       = 32'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TRANS:
            begin
                cur_state_next = trans_node;
                nmem_req.addr  = trans_node;
                node_next      = trans_node;
                steps_next     = SW'(1);
            end
            ST_WALK:
            begin
                nmem_req.addr = nmem_rsp.link;
                if (nmem_rsp.term)
                begin
                    emit_valid      = pend_valid_reg;
                    pend_state_next = node_reg;
                    pend_valid_next = 1'b1;
                end
                if (!walk_end)
                begin
                    node_next  = nmem_rsp.link;
                    steps_next = steps_reg + SW'(1);
                end
            end
            ST_DONE:
            begin
                emit_valid      = pend_valid_reg;
                emit_last       = 1'b1;
                pos_next        = pos_reg + 32'd1;
                pend_valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= ST_IDLE;
            cur_state_reg  <= 8'd0;
            pos_reg        <= 32'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            steps_reg      <= '0;
            sym_ok_reg     <= 1'b0;
        end
        else
        begin
            fsm_reg        <= fsm_next;
            cur_state_reg  <= cur_state_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= emit_valid;
            steps_reg      <= steps_next;
            sym_ok_reg     <= sym_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        pend_state_reg <= pend_state_next;
        out_pos_reg    <= pos_reg;
        out_state_reg  <= emit_state;
        out_last_reg   <= emit_last;
    end

    assign match_valid = out_valid_reg;
    assign position    = out_pos_reg;
    assign match_state = out_state_reg;
    assign last_match  = out_last_reg;

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        match_valid && last_match |=> !match_valid)
        else $error("A result followed the last result of a byte.");

    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        match_valid && !last_match |-> busy)
        else $error("A non-final result appeared with the walk already finished.");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_WALK) |-> (steps_reg != '0) && (steps_reg <= CHAIN_LIM))
        else $error("Suffix-link walk step count is out of bounds.");

    a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd != CMD_SCAN) |=> !busy && !match_valid)
        else $error("A table write or restart left the block busy or made a result.");

endmodule

// File: tb/multi_pattern_dfa_scanner_unit_tb.sv
// Self-checking testbench for the multi-pattern DFA scanner: directed table, then random automata.
module multi_pattern_dfa_scanner_unit_tb;
    import mpds_pkg::*;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int RANDOM_ITEMS   = 380;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIRECTED_ROWS  = 24;

    typedef struct {
        logic [31:0] pos;
        logic [7:0]  mst;
        logic        last;
    } match_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  sym;
        logic [7:0]  st;
        logic [7:0]  val;
        bit          typed;
        int          tn;
        logic [31:0] tpos;
        logic [7:0]  tmst;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  command;
    logic [7:0]  symbol;
    logic [7:0]  state_index;
    logic [7:0]  table_value;
    logic        match_valid;
    logic [31:0] position;
    logic [7:0]  match_state;
    logic        last_match;

    bit [7:0]    next_state_mem [0:255][0:255];
    bit          term_mem [0:255];
    bit [7:0]    link_mem [0:255];
    logic [7:0]  cur_state;
    logic [31:0] scan_pos;

    match_t      step_matches [$];
    match_t      pending_matches [$];

    bit [7:0]    phase_states [0:7];
    int          n_states;
    bit [7:0]    phase_syms [0:5];
    int          n_syms;

    bit          burst_mode;
    bit          typed_row;
    int          typed_n;
    match_t      typed_hit;

    int          fault_count;
    int          transfer_count;
    int          scan_count;
    int          write_count;
    int          checked_count;
    int          phase_count;
    int          rand_items;

    dir_row_t    dir_rows [0:DIRECTED_ROWS-1];

    multi_pattern_dfa_scanner_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .symbol      (symbol),
        .state_index (state_index),
        .table_value (table_value),
        .match_valid (match_valid),
        .position    (position),
        .match_state (match_state),
        .last_match  (last_match)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit state_in_phase(input logic [7:0] v);
        for (int i = 0; i < n_states; i++)
        begin
            if (phase_states[i] == v)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit sym_in_phase(input logic [7:0] v);
        for (int i = 0; i < n_syms; i++)
        begin
            if (phase_syms[i] == v)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick_state();
        return phase_states[$urandom_range(0, n_states - 1)];
    endfunction

    function automatic logic [7:0] pick_sym();
        return phase_syms[$urandom_range(0, n_syms - 1)];
    endfunction

    // Steps the automaton by one command and collects the detections it causes.
    function automatic void walk_automaton(input logic [2:0] cmd, input logic [7:0] sym,
                                           input logic [7:0] st, input logic [7:0] val);
        logic [7:0] node;
        match_t     hit;
        step_matches.delete();
        case (cmd)
            CMD_WRITE_EDGE:
            begin
                if (int'(st) < STATE_COUNT_DEF && int'(sym) < SYMBOL_COUNT_DEF)
                begin
                    next_state_mem[sym][st] = val;
                end
            end
            CMD_WRITE_TERM:
            begin
                if (int'(st) < STATE_COUNT_DEF)
                begin
                    term_mem[st] = (val != 8'd0);
                end
            end
            CMD_WRITE_LINK:
            begin
                if (int'(st) < STATE_COUNT_DEF)
                begin
                    link_mem[st] = val;
                end
            end
            CMD_RESTART:
            begin
                cur_state = 8'd0;
                scan_pos  = 32'd0;
            end
            CMD_SCAN:
            begin
                if (int'(sym) < SYMBOL_COUNT_DEF)
                begin
                    cur_state = next_state_mem[sym][cur_state];
                end
                else
                begin
                    cur_state = 8'd0;
                end
                node = cur_state;
                for (int k = 0; k < MAX_CHAIN_DEF && node != 8'd0; k++)
                begin
                    if (term_mem[node])
                    begin
                        hit.pos  = scan_pos;
                        hit.mst  = node;
                        hit.last = 1'b0;
                        step_matches.push_back(hit);
                    end
                    node = link_mem[node];
                end
                if (step_matches.size() > 0)
                begin
                    hit = step_matches.pop_back();
                    hit.last = 1'b1;
                    step_matches.push_back(hit);
                end
                scan_pos = scan_pos + 32'd1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Waits out a random gap unless in burst mode, presents one command and holds it until taken.
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] sym,
                             input logic [7:0] st, input logic [7:0] val);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        symbol      <= sym;
        state_index <= st;
        table_value <= val;
        do @(posedge clk); while (busy);
        walk_automaton(cmd, sym, st, val);
        if (typed_row)
        begin
            if (typed_n > 0)
            begin
                pending_matches.push_back(typed_hit);
            end
        end
        else
        begin
            foreach (step_matches[i])
            begin
                pending_matches.push_back(step_matches[i]);
            end
        end
        transfer_count++;
        if (cmd == CMD_SCAN)
        begin
            scan_count++;
        end
        else if (cmd == CMD_WRITE_EDGE || cmd == CMD_WRITE_TERM || cmd == CMD_WRITE_LINK)
        begin
            write_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        match_t want;
        if (rst_n && match_valid)
        begin
            if (pending_matches.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                begin
                    $display("Unexpected result: position %0d state %0d last %0b",
                             position, match_state, last_match);
                end
            end
            else
            begin
                want = pending_matches.pop_front();
                checked_count++;
                if (position !== want.pos || match_state !== want.mst || last_match !== want.last)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                    begin
                        $display("Mismatch: expected position %0d state %0d last %0b, got %0d %0d %0b",
                                 want.pos, want.mst, want.last, position, match_state, last_match);
                    end
                end
            end
        end
    end

    initial
    begin
        int          target;
        int          mix_len;
        int          bias;
        int          r;
        logic [7:0]  v;
        logic [7:0]  s;
        logic [7:0]  c;

        fault_count    = 0;
        transfer_count = 0;
        scan_count     = 0;
        write_count    = 0;
        checked_count  = 0;
        phase_count    = 0;
        rand_items     = 0;
        burst_mode     = 1'b0;
        typed_row      = 1'b0;
        typed_n        = 0;
        cur_state      = 8'd0;
        scan_pos       = 32'd0;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        command     <= CMD_RESTART;
        symbol      <= 8'd0;
        state_index <= 8'd0;
        table_value <= 8'd0;

        dir_rows[0]  = '{CMD_WRITE_EDGE, 8'h00, 8'h00, 8'h00, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[1]  = '{CMD_SCAN,       8'h00, 8'h00, 8'h00, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[2]  = '{CMD_WRITE_TERM, 8'h00, 8'hFF, 8'hFF, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[3]  = '{CMD_WRITE_LINK, 8'h00, 8'hFF, 8'h00, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[4]  = '{CMD_WRITE_EDGE, 8'hFF, 8'h00, 8'hFF, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[5]  = '{CMD_SCAN,       8'hFF, 8'h00, 8'h00, 1'b1, 1, 32'd1, 8'hFF};
        dir_rows[6]  = '{CMD_WRITE_EDGE, 8'hFF, 8'hFF, 8'h01, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[7]  = '{CMD_WRITE_TERM, 8'h00, 8'h01, 8'h01, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[8]  = '{CMD_WRITE_LINK, 8'h00, 8'h01, 8'hFF, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[9]  = '{CMD_SCAN,       8'hFF, 8'h00, 8'h00, 1'b0, 0, 32'd0, 8'h00};
        dir_rows[10] = '{CMD_WRITE_TERM, 8'h00, 8'hFF, 8'h00, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[11] = '{CMD_WRITE_EDGE, 8'hFF, 8'h01, 8'h01, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[12] = '{CMD_SCAN,       8'hFF, 8'h00, 8'h00, 1'b0, 0, 32'd0, 8'h00};
        dir_rows[13] = '{CMD_SPARE_FIRST, 8'hFF, 8'hFF, 8'hFF, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[14] = '{CMD_SPARE_LAST, 8'h00, 8'h00, 8'h00, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[15] = '{CMD_WRITE_LINK, 8'h00, 8'h01, 8'h02, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[16] = '{CMD_WRITE_TERM, 8'h00, 8'h02, 8'h80, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[17] = '{CMD_WRITE_LINK, 8'h00, 8'h02, 8'h01, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[18] = '{CMD_SCAN,       8'hFF, 8'h00, 8'h00, 1'b0, 0, 32'd0, 8'h00};
        dir_rows[19] = '{CMD_WRITE_TERM, 8'h00, 8'h02, 8'h00, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[20] = '{CMD_SCAN,       8'hFF, 8'h00, 8'h00, 1'b0, 0, 32'd0, 8'h00};
        dir_rows[21] = '{CMD_RESTART,    8'h00, 8'h00, 8'h00, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[22] = '{CMD_SCAN,       8'h00, 8'h00, 8'h00, 1'b1, 0, 32'd0, 8'h00};
        dir_rows[23] = '{CMD_SCAN,       8'hFF, 8'h00, 8'h00, 1'b1, 0, 32'd0, 8'h00};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            typed_row     = dir_rows[i].typed;
            typed_n       = dir_rows[i].tn;
            typed_hit.pos  = dir_rows[i].tpos;
            typed_hit.mst  = dir_rows[i].tmst;
            typed_hit.last = 1'b1;
            send_item(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].st, dir_rows[i].val);
        end
        typed_row = 1'b0;

        // Each setup restarts, loads a small automaton over a few symbols, then runs a random command mix.
        // Every table entry that a scan can reach is written before the first scan.
        while (rand_items < RANDOM_ITEMS)
        begin
            burst_mode = ($urandom_range(0, 3) == 0);
            n_states = 1;
            phase_states[0] = 8'd0;
            n_syms = 0;
            if (phase_count == 0)
            begin
                phase_states[1] = 8'hFF;
                n_states = 2;
                phase_syms[0] = 8'h00;
                phase_syms[1] = 8'hFF;
                n_syms = 2;
            end
            target = $urandom_range(2, 8);
            while (n_states < target)
            begin
                v = 8'($urandom_range(1, 255));
                if (!state_in_phase(v))
                begin
                    phase_states[n_states] = v;
                    n_states++;
                end
            end
            target = $urandom_range(2, 5);
            while (n_syms < target)
            begin
                v = 8'($urandom_range(0, 255));
                if (!sym_in_phase(v))
                begin
                    phase_syms[n_syms] = v;
                    n_syms++;
                end
            end
            bias = $urandom_range(25, 75);

            send_item(CMD_RESTART, 8'($urandom), 8'($urandom), 8'($urandom));
            rand_items++;
            for (int a = 0; a < n_syms; a++)
            begin
                for (int b = 0; b < n_states; b++)
                begin
                    send_item(CMD_WRITE_EDGE, phase_syms[a], phase_states[b], pick_state());
                    rand_items++;
                end
            end
            for (int b = 0; b < n_states; b++)
            begin
                v = ($urandom_range(0, 99) < bias) ? 8'($urandom_range(1, 255)) : 8'd0;
                send_item(CMD_WRITE_TERM, 8'($urandom), phase_states[b], v);
                send_item(CMD_WRITE_LINK, 8'($urandom), phase_states[b], pick_state());
                rand_items += 2;
            end

            mix_len = $urandom_range(40, 70);
            for (int m = 0; m < mix_len; m++)
            begin
                r = $urandom_range(0, 99);
                if (r < 72)
                begin
                    send_item(CMD_SCAN, pick_sym(), 8'($urandom), 8'($urandom));
                    rand_items++;
                end
                else if (r < 82)
                begin
                    c = ($urandom_range(0, 1) == 0) ? pick_sym() : 8'($urandom);
                    s = ($urandom_range(0, 1) == 0) ? pick_state() : 8'($urandom);
                    v = (sym_in_phase(c) && state_in_phase(s)) ? pick_state() : 8'($urandom);
                    send_item(CMD_WRITE_EDGE, c, s, v);
                    rand_items++;
                end
                else if (r < 87)
                begin
                    s = ($urandom_range(0, 1) == 0) ? pick_state() : 8'($urandom);
                    v = state_in_phase(s) ? pick_state() : 8'($urandom);
                    send_item(CMD_WRITE_LINK, 8'($urandom), s, v);
                    rand_items++;
                end
                else if (r < 92)
                begin
                    s = ($urandom_range(0, 1) == 0) ? pick_state() : 8'($urandom);
                    v = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
                    send_item(CMD_WRITE_TERM, 8'($urandom), s, v);
                    rand_items++;
                end
                else if (r < 95)
                begin
                    send_item(CMD_RESTART, 8'($urandom), 8'($urandom), 8'($urandom));
                    rand_items++;
                end
                else
                begin
                    send_item(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                              8'($urandom), 8'($urandom), 8'($urandom));
                end
            end
            phase_count++;
        end

        start <= 1'b0;
        while (pending_matches.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (MAX_CHAIN_DEF + 4) @(posedge clk);

        if (pending_matches.size() != 0)
        begin
            fault_count++;
            $display("%0d expected results never arrived", pending_matches.size());
        end

        $display("Ran %0d transfers: %0d scan bytes and %0d table writes over %0d automata.",
                 transfer_count, scan_count, write_count, phase_count);
        $display("Checked %0d detections; %0d faults found.", checked_count, fault_count);
        if (fault_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
